// ===== rtl/core/gbfp_pkg.sv =====
// shared types, constants and helpers for the binary frame parser
package gbfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned TallyW  = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned KindW   = 3;

  // result beat payload: all output fields except result_kind, padded to bytes
  localparam int unsigned ResBits  = ByteW + LenW + StatusW + ByteW + ByteW + LenW + KindW
                                     + TallyW + TallyW;
  localparam int unsigned ResDataW = ((ResBits + 7) / 8) * 8;
  localparam int unsigned ResPadW  = ResDataW - ResBits;

  localparam logic [ByteW-1:0] SyncFirst  = 8'hB5;
  localparam logic [ByteW-1:0] SyncSecond = 8'h62;

  localparam logic [LenW-1:0] MaxLenReset = 16'd1024;

  typedef enum logic [StatusW-1:0] {
    STATUS_GOOD    = 2'd0,
    STATUS_BAD_CK  = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } frame_status_e;

  typedef enum logic {
    RES_PAYLOAD = 1'b0,
    RES_STATUS  = 1'b1
  } result_kind_e;

  typedef enum logic [KindW-1:0] {
    KIND_OTHER   = 3'd0,
    KIND_ACK     = 3'd1,
    KIND_NACK    = 3'd2,
    KIND_CFG     = 3'd3,
    KIND_PVT     = 3'd4,
    KIND_POSECEF = 3'd5,
    KIND_VELECEF = 3'd6
  } msg_kind_e;

  // one-hot parse phase
  typedef enum logic [8:0] {
    PH_SYNC1   = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_IDENT   = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CK_A    = 9'b010000000,
    PH_CK_B    = 9'b100000000
  } phase_e;

  localparam logic [ByteW-1:0] ClassNav = 8'h01;
  localparam logic [ByteW-1:0] ClassAck = 8'h05;
  localparam logic [ByteW-1:0] ClassCfg = 8'h06;

  // message ids within the ack and nav classes
  localparam logic [ByteW-1:0] IdNack    = 8'h00;
  localparam logic [ByteW-1:0] IdAck     = 8'h01;
  localparam logic [ByteW-1:0] IdPosecef = 8'h01;
  localparam logic [ByteW-1:0] IdPvt     = 8'h07;
  localparam logic [ByteW-1:0] IdVelecef = 8'h11;

  function automatic msg_kind_e kind_of(input logic [ByteW-1:0] cls,
                                        input logic [ByteW-1:0] idn);
    msg_kind_e k;
    k = KIND_OTHER;
    if (cls == ClassAck) begin
      if (idn == IdAck) k = KIND_ACK;
      else if (idn == IdNack) k = KIND_NACK;
    end else if (cls == ClassCfg) begin
      k = KIND_CFG;
    end else if (cls == ClassNav) begin
      if (idn == IdPvt) k = KIND_PVT;
      else if (idn == IdPosecef) k = KIND_POSECEF;
      else if (idn == IdVelecef) k = KIND_VELECEF;
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/gnss_binary_frame_parser_core.sv =====
// binary receiver frame deframer with fletcher-8 check, one byte per beat
//
// channel   | dir | width | contents
// s_axis    | in  | 8     | tdata: rx_byte
// m_axis    | out | 96+1  | tuser: result_kind; tdata: payload_byte .. frames_good
// cfg       | in  | 16    | max_payload_len write, no read-back
//
// one byte per cycle unless a pending result is stalled by the sink; the parse state
// and the output register are both updated by the edge that takes the input beat
// a byte is taken whenever the output register is empty or being drained,
// so a stalled sink only blocks input once a result is pending
// rst_ni clears parse state, tallies and the limit (to 1024) asynchronously
// bytes that cause no result (sync, header, checksum a) never touch the output
module gnss_binary_frame_parser_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side: [7:0] rx_byte
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gbfp_pkg::ByteW-1:0]    s_axis_tdata,
  // master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] payload_byte, [23:8] byte_index, [25:24] frame_status,
  // [33:26] class_byte, [41:34] msg_id, [57:42] payload_len, [60:58] msg_kind,
  // [76:61] errors_seen, [92:77] frames_good, [95:93] zero
  output logic [gbfp_pkg::ResDataW-1:0] m_axis_tdata,
  // [0] result_kind
  output logic                          m_axis_tuser,
  // configuration: max_payload_len
  input  logic                          cfg_we_i,
  input  logic [gbfp_pkg::LenW-1:0]     cfg_wdata_i
);
  import gbfp_pkg::*;

  // parse state
  phase_e             phase_q, phase_d;
  logic [ByteW-1:0]   class_q, class_d;
  logic [ByteW-1:0]   ident_q, ident_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [LenW-1:0]    bytes_q, bytes_d;
  logic [ByteW-1:0]   sum_a_q, sum_a_d;
  logic [ByteW-1:0]   sum_b_q, sum_b_d;
  logic [ByteW-1:0]   rcv_a_q, rcv_a_d;
  logic [TallyW-1:0]  err_q, err_d;
  logic [TallyW-1:0]  good_q, good_d;
  logic [LenW-1:0]    max_len_q;

  // output register
  logic                m_valid_q;
  logic [ResDataW-1:0] out_data_q;
  logic                out_user_q;

  logic                acc;
  logic [ByteW-1:0]    rx;
  logic [ByteW-1:0]    na, nb;
  logic [LenW-1:0]     full_len;
  logic                emit;
  result_kind_e        res_kind;
  logic [ByteW-1:0]    res_byte;
  logic [LenW-1:0]     res_idx;
  frame_status_e       res_status;
  logic [ResDataW-1:0] res_data;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign rx            = s_axis_tdata;

  // running fletcher sums with this byte folded in
  assign na       = sum_a_q + rx;
  assign nb       = sum_b_q + na;
  assign full_len = {rx, len_q[ByteW-1:0]};

  always_comb begin
    phase_d    = phase_q;
    class_d    = class_q;
    ident_d    = ident_q;
    len_d      = len_q;
    bytes_d    = bytes_q;
    sum_a_d    = sum_a_q;
    sum_b_d    = sum_b_q;
    rcv_a_d    = rcv_a_q;
    err_d      = err_q;
    good_d     = good_q;
    emit       = 1'b0;
    res_kind   = RES_STATUS;
    res_byte   = '0;
    res_idx    = '0;
    res_status = STATUS_GOOD;

    if (acc) begin
      case (phase_q)
        PH_SYNC2: begin
          if (rx == SyncSecond) begin
            sum_a_d = '0;
            sum_b_d = '0;
            class_d = '0;
            ident_d = '0;
            len_d   = '0;
            bytes_d = '0;
            rcv_a_d = '0;
            phase_d = PH_CLASS;
          end else if (rx != SyncFirst) begin
            phase_d = PH_SYNC1;
          end
        end
        PH_CLASS: begin
          class_d = rx;
          sum_a_d = na;
          sum_b_d = nb;
          phase_d = PH_IDENT;
        end
        PH_IDENT: begin
          ident_d = rx;
          sum_a_d = na;
          sum_b_d = nb;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d   = {{(LenW-ByteW){1'b0}}, rx};
          sum_a_d = na;
          sum_b_d = nb;
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d   = full_len;
          sum_a_d = na;
          sum_b_d = nb;
          bytes_d = '0;
          if (full_len > max_len_q) begin
            // oversized frame: flag it and go back to hunting
            err_d      = err_q + 1'b1;
            phase_d    = PH_SYNC1;
            emit       = 1'b1;
            res_status = STATUS_TOO_LONG;
          end else if (full_len == '0) begin
            phase_d = PH_CK_A;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_a_d  = na;
          sum_b_d  = nb;
          bytes_d  = bytes_q + 1'b1;
          if (bytes_d == len_q) phase_d = PH_CK_A;
          emit     = 1'b1;
          res_kind = RES_PAYLOAD;
          res_byte = rx;
          res_idx  = bytes_q;
        end
        PH_CK_A: begin
          rcv_a_d = rx;
          phase_d = PH_CK_B;
        end
        PH_CK_B: begin
          if (rcv_a_q == sum_a_q && rx == sum_b_q) begin
            good_d     = good_q + 1'b1;
            res_status = STATUS_GOOD;
          end else begin
            err_d      = err_q + 1'b1;
            res_status = STATUS_BAD_CK;
          end
          phase_d = PH_SYNC1;
          emit    = 1'b1;
        end
        default: begin
          // hunting the first sync byte
          phase_d = (rx == SyncFirst) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
  end

  // header fields and tallies are taken after this byte's update
  assign res_data = {{ResPadW{1'b0}}, good_d, err_d, kind_of(class_d, ident_d), len_d,
                     ident_d, class_d, res_status, res_idx, res_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SYNC1;
      class_q   <= '0;
      ident_q   <= '0;
      len_q     <= '0;
      bytes_q   <= '0;
      sum_a_q   <= '0;
      sum_b_q   <= '0;
      rcv_a_q   <= '0;
      err_q     <= '0;
      good_q    <= '0;
      max_len_q <= MaxLenReset;
      m_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      class_q <= class_d;
      ident_q <= ident_d;
      len_q   <= len_d;
      bytes_q <= bytes_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      rcv_a_q <= rcv_a_d;
      err_q   <= err_d;
      good_q  <= good_d;
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
      // output register fills on a result, drains on a sink beat
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each result and qualified by m_valid_q
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= res_data;
      out_user_q <= res_kind;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // a payload byte always produces a payload beat next cycle
  a_payload_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && phase_q == PH_PAYLOAD |=> m_valid_q && out_user_q == RES_PAYLOAD)
    else $error("payload byte did not produce a payload beat");

  // second checksum byte always produces a status beat
  a_status_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && phase_q == PH_CK_B |=> m_valid_q && out_user_q == RES_STATUS)
    else $error("checksum byte did not produce a status beat");

  // payload phase never runs past the declared length
  a_payload_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> bytes_q < len_q)
    else $error("payload count reached declared length inside payload phase");

  // tallies move only on an accepted byte
  a_tally_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(err_q) && $stable(good_q))
    else $error("tally changed without an input beat");

endmodule
